>>> sv/lpht_pkg.sv
// Shared constants, codes and control structs for the linear-probe hash table.
// Used by lpht_ctrl, lpht_dp and linear_probe_hash_table_core.
package lpht_pkg;

	localparam int TABLE_DEPTH = 16;
	localparam int SLOT_W      = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
	localparam int WORD_W      = 64;
	localparam int BYTE_W      = 8;
	localparam int BITCNT_W    = $clog2(BYTE_W);

	localparam logic [CNT_W-1:0] SLOTS_RESET = CNT_W'(10);

	// register index (byte address / 4)
	localparam logic REG_SLOTS_IN_USE = 1'b0;

	localparam logic [1:0] CMD_INSERT = 2'd0;
	localparam logic [1:0] CMD_UPDATE = 2'd1;
	localparam logic [1:0] CMD_LOOKUP = 2'd2;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_DUP     = 2'd1;
	localparam logic [1:0] ST_FULL    = 2'd2;
	localparam logic [1:0] ST_MISSING = 2'd3;

	typedef struct packed {
		logic load;       // take the input word
		logic hash_step;  // one remainder bit
		logic probe_step; // examine one slot
		logic commit;     // write table, load output register
	} dp_cmd_t;

	typedef struct packed {
		logic hash_last;
		logic probe_last;
		logic hit;
		logic out_busy;
	} dp_stat_t;

endpackage

>>> sv/lpht_ctrl.sv
// Control state machine for the linear-probe hash table.
// Depends on lpht_pkg; drives lpht_dp through dp_cmd_t / dp_stat_t.
module lpht_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  lpht_pkg::dp_stat_t stat,
	output lpht_pkg::dp_cmd_t  cmd
);

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_HASH  = 4'b0010,
		S_PROBE = 4'b0100,
		S_DONE  = 4'b1000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_HASH;
				end
			end
			S_HASH: begin
				cmd.hash_step = 1'b1;
				if (stat.hash_last) begin
					state_d = S_PROBE;
				end
			end
			S_PROBE: begin
				cmd.probe_step = 1'b1;
				if (stat.hit || stat.probe_last) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (!stat.out_busy) begin
					cmd.commit = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign in_ready = (state_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

>>> sv/lpht_dp.sv
// Datapath: key/value stores, occupied bits, home-slot remainder unit,
// probe pointer and output register. Depends on lpht_pkg.
module lpht_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic [lpht_pkg::CNT_W-1:0]          n_eff,
	input  lpht_pkg::dp_cmd_t                   cmd,
	output lpht_pkg::dp_stat_t                  stat,
	input  logic [1:0]                          command,
	input  logic [lpht_pkg::WORD_W-1:0]         key_word,
	input  logic [lpht_pkg::WORD_W-1:0]         value_word,
	input  logic                                out_stall,
	output logic                                out_valid,
	output logic [1:0]                          status,
	output logic [3:0]                          slot_index,
	output logic [lpht_pkg::WORD_W-1:0]         value_out
);

	localparam int SW = lpht_pkg::SLOT_W;
	localparam int CW = lpht_pkg::CNT_W;
	localparam int WW = lpht_pkg::WORD_W;

	logic [WW-1:0] key_mem [lpht_pkg::TABLE_DEPTH];
	logic [WW-1:0] val_mem [lpht_pkg::TABLE_DEPTH];
	logic [lpht_pkg::TABLE_DEPTH-1:0] occ_q;

	logic [1:0]    cmd_q;
	logic [WW-1:0] key_q, val_q;

	logic [lpht_pkg::BITCNT_W-1:0] bitcnt_q;
	logic [SW-1:0] rem_q;
	logic [CW-1:0] rem_shift, rem_next;

	logic [SW-1:0] ptr_q, probe_cnt_q, found_slot_q, free_slot_q;
	logic [CW-1:0] ptr_inc;
	logic          found_q, free_found_q;
	logic          hit;

	logic          out_valid_q;
	logic [1:0]    status_q, status_d;
	logic [3:0]    slot_q, slot_d;
	logic [WW-1:0] vout_q, vout_d;
	logic          do_insert, do_update;

	logic [lpht_pkg::BYTE_W-1:0] top_byte;

	// restoring remainder, top byte MSB first: r stays below n_eff
	assign top_byte  = key_q[WW-1 -: lpht_pkg::BYTE_W];
	assign rem_shift = {rem_q, top_byte[~bitcnt_q]};
	assign rem_next  = (rem_shift >= n_eff) ? (rem_shift - n_eff) : rem_shift;

	assign ptr_inc = CW'(ptr_q) + CW'(1);
	assign hit     = occ_q[ptr_q] && (key_mem[ptr_q] == key_q);

	assign stat.hash_last  = (bitcnt_q == '1);
	assign stat.probe_last = (CW'(probe_cnt_q) == n_eff - CW'(1));
	assign stat.hit        = hit;
	assign stat.out_busy   = out_valid_q && out_stall;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q    <= command;
			key_q    <= key_word;
			val_q    <= value_word;
			bitcnt_q <= '0;
			rem_q    <= '0;
		end
		if (cmd.hash_step) begin
			bitcnt_q <= bitcnt_q + 1'b1;
			rem_q    <= rem_next[SW-1:0];
			if (stat.hash_last) begin
				ptr_q        <= rem_next[SW-1:0];
				probe_cnt_q  <= '0;
				found_q      <= 1'b0;
				free_found_q <= 1'b0;
			end
		end
		if (cmd.probe_step) begin
			probe_cnt_q <= probe_cnt_q + 1'b1;
			ptr_q       <= (ptr_inc >= n_eff) ? '0 : ptr_inc[SW-1:0];
			if (hit) begin
				found_q      <= 1'b1;
				found_slot_q <= ptr_q;
			end
			// first empty slot on the path is where an insert lands
			if (!occ_q[ptr_q] && !free_found_q) begin
				free_found_q <= 1'b1;
				free_slot_q  <= ptr_q;
			end
		end
	end

	always_comb begin
		status_d  = lpht_pkg::ST_OK;
		slot_d    = '0;
		vout_d    = '0;
		do_insert = 1'b0;
		do_update = 1'b0;
		unique case (cmd_q)
			lpht_pkg::CMD_INSERT: begin
				if (found_q) begin
					status_d = lpht_pkg::ST_DUP;
				end else if (free_found_q) begin
					slot_d    = 4'(free_slot_q);
					do_insert = 1'b1;
				end else begin
					status_d = lpht_pkg::ST_FULL;
				end
			end
			lpht_pkg::CMD_UPDATE: begin
				if (found_q) begin
					slot_d    = 4'(found_slot_q);
					do_update = 1'b1;
				end else begin
					status_d = lpht_pkg::ST_MISSING;
				end
			end
			default: begin
				if (found_q) begin
					slot_d = 4'(found_slot_q);
					vout_d = val_mem[found_slot_q];
				end else begin
					status_d = lpht_pkg::ST_MISSING;
				end
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.commit && do_insert) begin
			key_mem[free_slot_q] <= key_q;
			val_mem[free_slot_q] <= val_q;
		end
		if (cmd.commit && do_update) begin
			val_mem[found_slot_q] <= val_q;
		end
		if (cmd.commit) begin
			status_q <= status_d;
			slot_q   <= slot_d;
			vout_q   <= vout_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.commit && do_insert) begin
				occ_q[free_slot_q] <= 1'b1;
			end
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign slot_index = slot_q;
	assign value_out  = vout_q;

endmodule

>>> sv/linear_probe_hash_table_core.sv
// Linear-probe hash table, top level: APB register, controller, datapath.
// Depends on lpht_pkg, lpht_ctrl and lpht_dp.
//
// Input channel (in_valid/in_stall) carries one word: command, key_word,
// value_word. Output channel (out_valid/out_stall) returns one word per input:
// status, slot_index, value_out. A word moves when valid is high and stall low.
// Each word: accept, then form the home slot (top key byte modulo the slot
// count, one remainder bit per cycle), then probe slots from there (up to the
// slot count in use, at most 16, stopping early on a key match), then write
// the table and load the output register once it is free. One word is in
// flight at a time; a new word is not taken until the last one is committed.
// A finished result waits in the output register while out_stall is high; the
// next input word can be taken meanwhile, but its result is held back until
// the output register frees. in_stall is high while a word is being worked.
// Reset clears all occupied bits and sets slots_in_use to 10; key and value
// stores hold nothing meaningful until written. slots_in_use sits at byte
// address 0; the user must write it only while the block is idle, which the
// block itself does not enforce. 0 acts as 1 and values above 16 act as 16.
module linear_probe_hash_table_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [2:0]                  paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [1:0]                  command,
	input  logic [lpht_pkg::WORD_W-1:0] key_word,
	input  logic [lpht_pkg::WORD_W-1:0] value_word,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [1:0]                  status,
	output logic [3:0]                  slot_index,
	output logic [lpht_pkg::WORD_W-1:0] value_out
);

	localparam int CW = lpht_pkg::CNT_W;

	logic [CW-1:0]      slots_q, n_eff;
	logic               in_ready;
	lpht_pkg::dp_cmd_t  cmd;
	lpht_pkg::dp_stat_t stat;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slots_q <= lpht_pkg::SLOTS_RESET;
		end else if (psel && penable && pwrite && pready
				&& paddr[2] == lpht_pkg::REG_SLOTS_IN_USE) begin
			slots_q <= pwdata[CW-1:0];
		end
	end

	assign prdata = (paddr[2] == lpht_pkg::REG_SLOTS_IN_USE) ? 32'(slots_q) : '0;

	always_comb begin
		priority if (slots_q == '0) begin
			n_eff = CW'(1);
		end else if (slots_q > CW'(lpht_pkg::TABLE_DEPTH)) begin
			n_eff = CW'(lpht_pkg::TABLE_DEPTH);
		end else begin
			n_eff = slots_q;
		end
	end

	lpht_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	lpht_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.n_eff      (n_eff),
		.cmd        (cmd),
		.stat       (stat),
		.command    (command),
		.key_word   (key_word),
		.value_word (value_word),
		.out_stall  (out_stall),
		.out_valid  (out_valid),
		.status     (status),
		.slot_index (slot_index),
		.value_out  (value_out)
	);

	assign in_stall = !in_ready;

	// a failed command never reports a slot or a value
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != lpht_pkg::ST_OK |-> slot_index == '0 && value_out == '0)
		else $error("nonzero slot or value on failed command");

	// an accepted word keeps the input side busy in the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input not stalled after accept");

	// a new result is only produced while a word is in work and the output is not blocked
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> in_stall && !(out_valid && out_stall))
		else $error("commit while idle or output blocked");

	// a found or placed slot lies inside the probed range
	a_slot_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == lpht_pkg::ST_OK |-> CW'(slot_index) < n_eff)
		else $error("slot beyond slot count");

endmodule
